>>> rtl/core/nslc_pkg.sv
package nslc_pkg;

  localparam int COORD_W = 11;
  localparam int CLS_W   = 3;
  localparam int RAD_W   = 13;
  localparam int SQ_W    = 2 * COORD_W;
  localparam int DIST_W  = SQ_W + 1;
  localparam int RSQ_W   = 2 * RAD_W;
  // L = 64*b + r*r - 64*a stays below 2^30 whenever b > a
  localparam int LEN_W   = 30;
  localparam int LSQ_W   = 2 * LEN_W;
  localparam int RSQB_W  = RSQ_W + DIST_W;

  // tag that travels with each site read out of the table
  typedef struct packed {
    logic vld;
    logic first;
    logic last;
  } rd_tag_t;

  // result of one walk over the site table
  typedef struct packed {
    logic               done;
    logic               have_b;
    logic [DIST_W-1:0]  dist_a;
    logic [DIST_W-1:0]  dist_b;
    logic [CLS_W-1:0]   best_cls;
  } scan_res_t;

endpackage

>>> rtl/core/nearest_site_label_check.sv
// Nearest-site label check.
// Input channel: an item is taken on a rising edge with start high and busy
// low. in_mode 0 writes one site (x, y, class) into the table slot
// in_site_index; slots at or above NUM_SITES are ignored and busy stays
// low. in_mode 1 tests one sample against the table.
// A sample reads the table one site per cycle through the single read port,
// so busy stays high after acceptance through the NUM_SITES reads, the read
// register, squares, minimum update and the bound arithmetic. A new item
// can follow once busy falls after a sample; a site load leaves busy low,
// so a new item can follow it in the next cycle.
// Result channel: on a sample with in_last_sample set, out_strobe is high
// for one cycle as busy falls, with out_all_match = AND of the test outcome
// of every sample since the previous result. The flag re-arms to one then.
// The receiver cannot stall; every result is taken in its strobe cycle.
// cfg_relaxed_enable selects the radius-tolerant test; write it while idle.
// Reset clears control state and the mode register and sets the pass flag;
// table contents are undefined until loaded.
module nearest_site_label_check #(
  parameter int NUM_SITES = 10
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic                         in_mode,
  input  logic [3:0]                   in_site_index,
  input  logic [nslc_pkg::COORD_W-1:0] in_pos_x,
  input  logic [nslc_pkg::COORD_W-1:0] in_pos_y,
  input  logic [nslc_pkg::CLS_W-1:0]   in_class_label,
  input  logic [nslc_pkg::RAD_W-1:0]   in_radius_q4,
  input  logic                         in_last_sample,
  output logic                         out_strobe,
  output logic                         out_all_match,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic                         cfg_relaxed_enable
);

  localparam int AW      = $clog2(NUM_SITES);
  localparam int ENTRY_W = 2 * nslc_pkg::COORD_W + nslc_pkg::CLS_W;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_WALK = 3'b010,
    ST_WAIT = 3'b100
  } state_t;

  state_t                       state_r, state_nxt;
  logic [AW-1:0]                rd_cnt_r, rd_cnt_nxt;
  logic                         relaxed_r;
  logic                         pass_r, pass_nxt;
  logic                         strobe_r, strobe_nxt;
  logic                         match_r, match_nxt;

  logic [nslc_pkg::COORD_W-1:0] smp_x_r, smp_y_r;
  logic [nslc_pkg::CLS_W-1:0]   smp_label_r;
  logic [nslc_pkg::RAD_W-1:0]   smp_r_r;
  logic                         smp_last_r;

  logic                         accept, wr_en, rd_en, last_rd, pass_now;
  logic [ENTRY_W-1:0]           rd_data;
  nslc_pkg::rd_tag_t            tag_r, tag_nxt;
  nslc_pkg::scan_res_t          scan_res;
  logic                         ok_vld, ok;

  assign accept  = start & ~busy;
  assign wr_en   = accept & ~in_mode & ({1'b0, in_site_index} < 5'(NUM_SITES));
  assign rd_en   = (state_r == ST_WALK);
  assign last_rd = (rd_cnt_r == AW'(NUM_SITES - 1));

  nslc_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(NUM_SITES)
  ) u_site_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (in_site_index[AW-1:0]),
    .wdata ({in_pos_x, in_pos_y, in_class_label}),
    .re    (rd_en),
    .raddr (rd_cnt_r),
    .rdata (rd_data)
  );

  always_comb begin
    tag_nxt.vld   = rd_en;
    tag_nxt.first = rd_en & (rd_cnt_r == '0);
    tag_nxt.last  = rd_en & last_rd;
  end

  nslc_scan u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .tag       (tag_r),
    .site_x    (rd_data[ENTRY_W-1 -: nslc_pkg::COORD_W]),
    .site_y    (rd_data[nslc_pkg::CLS_W +: nslc_pkg::COORD_W]),
    .site_cls  (rd_data[nslc_pkg::CLS_W-1:0]),
    .smp_x     (smp_x_r),
    .smp_y     (smp_y_r),
    .smp_label (smp_label_r),
    .res       (scan_res)
  );

  nslc_judge u_judge (
    .clk       (clk),
    .rst_n     (rst_n),
    .res       (scan_res),
    .relaxed   (relaxed_r),
    .smp_label (smp_label_r),
    .smp_r     (smp_r_r),
    .ok_vld    (ok_vld),
    .ok        (ok)
  );

  assign pass_now = pass_r & ok;

  always_comb begin
    state_nxt  = state_r;
    rd_cnt_nxt = rd_cnt_r;
    pass_nxt   = pass_r;
    strobe_nxt = 1'b0;
    match_nxt  = match_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && in_mode) begin
          state_nxt  = ST_WALK;
          rd_cnt_nxt = '0;
        end
      end
      ST_WALK: begin
        rd_cnt_nxt = rd_cnt_r + AW'(1);
        if (last_rd) begin
          state_nxt = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (ok_vld) begin
          state_nxt = ST_IDLE;
          if (smp_last_r) begin
            strobe_nxt = 1'b1;
            match_nxt  = pass_now;
            pass_nxt   = 1'b1;
          end else begin
            pass_nxt = pass_now;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      rd_cnt_r  <= '0;
      pass_r    <= 1'b1;
      strobe_r  <= 1'b0;
      match_r   <= 1'b0;
      relaxed_r <= 1'b0;
      tag_r     <= '0;
    end else begin
      state_r  <= state_nxt;
      rd_cnt_r <= rd_cnt_nxt;
      pass_r   <= pass_nxt;
      strobe_r <= strobe_nxt;
      match_r  <= match_nxt;
      tag_r    <= tag_nxt;
      if (cfg_valid && cfg_ready) begin
        relaxed_r <= cfg_relaxed_enable;
      end
    end
  end

  // hold the sample for the whole walk
  always_ff @(posedge clk) begin
    if (accept && in_mode) begin
      smp_x_r     <= in_pos_x;
      smp_y_r     <= in_pos_y;
      smp_label_r <= in_class_label;
      smp_r_r     <= in_radius_q4;
      smp_last_r  <= in_last_sample;
    end
  end

  assign busy          = (state_r != ST_IDLE);
  assign cfg_ready     = 1'b1;
  assign out_strobe    = strobe_r;
  assign out_all_match = match_r;

endmodule

>>> rtl/core/nslc_ram.sv
module nslc_ram #(
  parameter int WIDTH = 25,
  parameter int DEPTH = 10
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/core/nslc_scan.sv
module nslc_scan (
  input  logic                         clk,
  input  logic                         rst_n,
  input  nslc_pkg::rd_tag_t            tag,
  input  logic [nslc_pkg::COORD_W-1:0] site_x,
  input  logic [nslc_pkg::COORD_W-1:0] site_y,
  input  logic [nslc_pkg::CLS_W-1:0]   site_cls,
  input  logic [nslc_pkg::COORD_W-1:0] smp_x,
  input  logic [nslc_pkg::COORD_W-1:0] smp_y,
  input  logic [nslc_pkg::CLS_W-1:0]   smp_label,
  output nslc_pkg::scan_res_t          res
);

  logic [nslc_pkg::COORD_W-1:0] dx, dy;
  logic [nslc_pkg::SQ_W-1:0]    sqx_r, sqy_r;
  logic [nslc_pkg::CLS_W-1:0]   cls_r;
  nslc_pkg::rd_tag_t            tag_r;

  logic [nslc_pkg::DIST_W-1:0]  dist_sum;
  logic                         have_b_eff;
  logic [nslc_pkg::DIST_W-1:0]  dist_a_r, dist_b_r;
  logic [nslc_pkg::CLS_W-1:0]   best_cls_r;
  logic                         have_b_r, done_r;

  assign dx = (site_x > smp_x) ? site_x - smp_x : smp_x - site_x;
  assign dy = (site_y > smp_y) ? site_y - smp_y : smp_y - site_y;

  // stage A: squares
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r <= '0;
    end else begin
      tag_r <= tag;
    end
    sqx_r <= dx * dx;
    sqy_r <= dy * dy;
    cls_r <= site_cls;
  end

  assign dist_sum   = {1'b0, sqx_r} + {1'b0, sqy_r};
  assign have_b_eff = tag_r.first ? 1'b0 : have_b_r;

  // stage B: running minimum overall and over the sample's label
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r   <= 1'b0;
      have_b_r <= 1'b0;
    end else begin
      done_r <= tag_r.vld & tag_r.last;
      if (tag_r.vld) begin
        if (tag_r.first || dist_sum < dist_a_r) begin
          dist_a_r   <= dist_sum;
          best_cls_r <= cls_r;
        end
        if (cls_r == smp_label && (!have_b_eff || dist_sum < dist_b_r)) begin
          dist_b_r <= dist_sum;
          have_b_r <= 1'b1;
        end else begin
          have_b_r <= have_b_eff;
        end
      end
    end
  end

  assign res.done     = done_r;
  assign res.have_b   = have_b_r;
  assign res.dist_a   = dist_a_r;
  assign res.dist_b   = dist_b_r;
  assign res.best_cls = best_cls_r;

endmodule

>>> rtl/core/nslc_judge.sv
module nslc_judge (
  input  logic                        clk,
  input  logic                        rst_n,
  input  nslc_pkg::scan_res_t         res,
  input  logic                        relaxed,
  input  logic [nslc_pkg::CLS_W-1:0]  smp_label,
  input  logic [nslc_pkg::RAD_W-1:0]  smp_r,
  output logic                        ok_vld,
  output logic                        ok
);

  logic [nslc_pkg::RSQ_W-1:0]  rsq_r;
  logic [nslc_pkg::LEN_W:0]    len_full;

  logic                        v1_r, v2_r, v3_r;
  logic                        exact1_r, hb1_r, easy1_r;
  logic [nslc_pkg::LEN_W-1:0]  len1_r;
  logic [nslc_pkg::DIST_W-1:0] b1_r;

  logic                        exact2_r, hb2_r, easy2_r;
  logic [nslc_pkg::LSQ_W-1:0]  lsq2_r;
  logic [nslc_pkg::RSQB_W-1:0] rsqb2_r;

  logic                        ok3_r;
  logic                        far_ok;

  // r is held for the whole sample, so the square is ready before the walk ends
  always_ff @(posedge clk) begin
    rsq_r <= smp_r * smp_r;
  end

  assign len_full = (nslc_pkg::LEN_W+1)'({res.dist_b, 6'b0})
                  + (nslc_pkg::LEN_W+1)'(rsq_r)
                  - (nslc_pkg::LEN_W+1)'({res.dist_a, 6'b0});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= res.done;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
    // stage 1: cheap outcomes and the bound length
    exact1_r <= (res.best_cls == smp_label);
    hb1_r    <= res.have_b;
    easy1_r  <= (res.dist_b <= res.dist_a) ||
                ((nslc_pkg::RSQ_W+6)'({res.dist_b, 6'b0}) <= (nslc_pkg::RSQ_W+6)'(rsq_r));
    len1_r   <= len_full[nslc_pkg::LEN_W-1:0];
    b1_r     <= res.dist_b;
    // stage 2: products
    exact2_r <= exact1_r;
    hb2_r    <= hb1_r;
    easy2_r  <= easy1_r;
    lsq2_r   <= len1_r * len1_r;
    rsqb2_r  <= rsq_r * b1_r;
    // stage 3: squared-bound compare
    ok3_r    <= relaxed ? (hb2_r & (easy2_r | far_ok)) : exact2_r;
  end

  assign far_ok = lsq2_r <= nslc_pkg::LSQ_W'({rsqb2_r, 8'b0});

  assign ok_vld = v3_r;
  assign ok     = ok3_r;

endmodule

>>> rtl/core/nslc_chk.sv
module nslc_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        in_mode,
  input logic        out_strobe
);

  // a sample beat makes the block busy
  a_sample_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_mode |=> busy)
    else $error("sample beat did not raise busy");

  // a site load completes in the accept cycle
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && !in_mode |=> !busy)
    else $error("site load raised busy");

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy && $past(busy))
    else $error("result beat outside the end of a sample");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("result beat repeated");

endmodule

bind nearest_site_label_check nslc_chk u_nslc_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .in_mode    (in_mode),
  .out_strobe (out_strobe)
);
